[rtl/core/sjc_pkg.sv]
// shared types, constants and helpers for the shift-jis to utf-8 converter
package sjc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16384;
    localparam int IDX_W             = 14;
    localparam int WORD_W            = 16;

    typedef enum logic [0:0] {
        OP_CONVERT = 1'b0,
        OP_LOAD    = 1'b1
    } t_op;

    localparam logic [3:0] NIB_LEAD_A = 4'h8;
    localparam logic [3:0] NIB_LEAD_B = 4'h9;
    localparam logic [3:0] NIB_LEAD_C = 4'hE;

    localparam logic [IDX_W-1:0] BASE_A = 14'h0100;
    localparam logic [IDX_W-1:0] BASE_B = 14'h1100;
    localparam logic [IDX_W-1:0] BASE_C = 14'h2100;

    localparam logic [WORD_W-1:0] LIM_ONE = 16'h0080;
    localparam logic [WORD_W-1:0] LIM_TWO = 16'h0800;

    localparam logic [7:0] PFX_TWO  = 8'hC0;
    localparam logic [7:0] PFX_THREE = 8'hE0;
    localparam logic [7:0] PFX_CONT = 8'h80;

    // true when a byte opens a two-byte character
    function automatic logic is_lead(input logic [7:0] b);
        return (b[7:4] == NIB_LEAD_A) || (b[7:4] == NIB_LEAD_B) || (b[7:4] == NIB_LEAD_C);
    endfunction

    // stored base for a lead byte
    function automatic logic [IDX_W-1:0] lead_base(input logic [7:0] b);
        logic [IDX_W-1:0] base;
        base = BASE_A;
        case (b[7:4])
            NIB_LEAD_A: base = BASE_A;
            NIB_LEAD_B: base = BASE_B;
            NIB_LEAD_C: base = BASE_C;
            default:    base = BASE_A;
        endcase
        return base + {2'b00, b[3:0], 8'h00};
    endfunction

endpackage

[rtl/core/shiftjis_to_utf8_converter_unit.sv]
// shift-jis to utf-8 converter top level: table memory, lead tracking, byte serializer
//
//   channel  | direction | handshake               | payload
//   request  | in        | i_in_valid / o_in_stall | operation, data_byte, end_of_string,
//            |           |                         | table_index, table_word
//   output   | out       | o_out_valid/i_out_stall | utf8_byte, char_last, string_last
//
// a table load writes the memory at its accept edge
// a converted character passes the memory read register and the serializer and leaves
// as 1 to 3 bytes, one per unstalled cycle; the single output byte port sets the rate
// the memory read register holds one character while the serializer drains the previous
// one; once it is full the input stalls until the serializer takes the held character
// reset clears lead state and valids; table contents stay undefined until loaded
module shiftjis_to_utf8_converter_unit
    import sjc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_string,
    input  logic [IDX_W-1:0]    i_table_index,
    input  logic [WORD_W-1:0]   i_table_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_utf8_byte,
    output logic                o_char_last,
    output logic                o_string_last
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [WORD_W-1:0] r_mem [TABLE_ENTRIES];

    logic              r_lead_pending, n_lead_pending;
    logic [IDX_W-1:0]  r_lead_base,    n_lead_base;

    logic              r_rd_valid;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_oor;
    logic              r_rd_eos;

    logic              r_ov;
    logic [7:0]        r_bytes [3];
    logic [1:0]        r_left;
    logic              r_eos;

    logic              in_acc, conv_acc, load_acc, out_acc, ser_load;
    logic              byte_lead;
    logic              conv_read;
    logic [IDX_W-1:0]  rd_index;
    logic              rd_in_range, wr_in_range;
    logic [WORD_W-1:0] word;
    logic [7:0]        e_bytes [3];
    logic [1:0]        e_left;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign load_acc = in_acc && (t_op'(i_operation) == OP_LOAD);
    assign conv_acc = in_acc && (t_op'(i_operation) == OP_CONVERT);
    assign out_acc  = r_ov && !i_out_stall;

    // serializer takes a new character when empty or when its last byte leaves
    assign ser_load   = r_rd_valid && (!r_ov || (out_acc && (r_left == 2'd0)));
    assign o_in_stall = r_rd_valid && !ser_load;

    assign byte_lead = !r_lead_pending && is_lead(i_data_byte);
    assign conv_read = conv_acc && !byte_lead;
    assign rd_index  = r_lead_pending ? (r_lead_base + {6'd0, i_data_byte})
                                      : {6'd0, i_data_byte};
    assign rd_in_range = ({1'b0, rd_index} < (IDX_W+1)'(TABLE_ENTRIES));
    assign wr_in_range = ({1'b0, i_table_index} < (IDX_W+1)'(TABLE_ENTRIES));

    always_comb begin
        n_lead_pending = r_lead_pending;
        n_lead_base    = r_lead_base;
        if (conv_acc) begin
            if (byte_lead && !i_end_of_string) begin
                n_lead_pending = 1'b1;
                n_lead_base    = lead_base(i_data_byte);
            end else begin
                n_lead_pending = 1'b0;
                n_lead_base    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_acc && wr_in_range) begin
            r_mem[i_table_index[AW-1:0]] <= i_table_word;
        end
        if (conv_read && rd_in_range) begin
            r_rd_data <= r_mem[rd_index[AW-1:0]];
        end
        if (conv_read) begin
            r_rd_oor <= !rd_in_range;
            r_rd_eos <= i_end_of_string;
        end
    end

    // utf-8 encoding of the word just read
    always_comb begin
        word       = r_rd_oor ? '0 : r_rd_data;
        e_bytes[0] = word[7:0];
        e_bytes[1] = '0;
        e_bytes[2] = '0;
        e_left     = 2'd0;
        if (word >= LIM_TWO) begin
            e_bytes[0] = PFX_THREE | {4'd0, word[15:12]};
            e_bytes[1] = PFX_CONT  | {2'd0, word[11:6]};
            e_bytes[2] = PFX_CONT  | {2'd0, word[5:0]};
            e_left     = 2'd2;
        end else if (word >= LIM_ONE) begin
            e_bytes[0] = PFX_TWO  | {3'd0, word[10:6]};
            e_bytes[1] = PFX_CONT | {2'd0, word[5:0]};
            e_left     = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_bytes <= e_bytes;
            r_left  <= e_left;
            r_eos   <= r_rd_eos;
        end else if (out_acc) begin
            r_bytes[0] <= r_bytes[1];
            r_bytes[1] <= r_bytes[2];
            r_left     <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_base    <= '0;
            r_rd_valid     <= 1'b0;
            r_ov           <= 1'b0;
        end else begin
            r_lead_pending <= n_lead_pending;
            r_lead_base    <= n_lead_base;
            if (conv_read) begin
                r_rd_valid <= 1'b1;
            end else if (ser_load) begin
                r_rd_valid <= 1'b0;
            end
            if (ser_load) begin
                r_ov <= 1'b1;
            end else if (out_acc && (r_left == 2'd0)) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_utf8_byte   = r_bytes[0];
    assign o_char_last   = (r_left == 2'd0);
    assign o_string_last = (r_left == 2'd0) && r_eos;

endmodule

[rtl/core/sjc_checker.sv]
// port-level checker for the shift-jis to utf-8 converter, bound to the top level
module sjc_checker
    import sjc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_utf8_byte,
    input logic        o_char_last,
    input logic        o_string_last
);

    // a stalled output byte stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_utf8_byte)
            && $stable(o_char_last))
        else $error("stalled output byte changed");

    // end of string only on the last byte of a character
    a_string_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_last |-> o_char_last)
        else $error("string_last without char_last");

    // the rest of a character follows with no gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_char_last |=> o_out_valid)
        else $error("gap inside a character");

    // bytes after the first one of a character are continuation bytes
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_char_last |=> o_utf8_byte[7:6] == PFX_CONT[7:6])
        else $error("missing continuation byte");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind shiftjis_to_utf8_converter_unit sjc_checker u_sjc_checker (.*);
